// ===== hw/rtl/lcc_pkg.sv =====
// shared types, constants and helpers for the lattice coordinate conversion unit
`default_nettype none

package lcc_pkg;

    localparam int COORD_W  = 32;                  // coordinate and register width
    localparam int FRAC_W   = 16;                  // fraction bits of the q16.16 format
    localparam int PROD_W   = 2 * COORD_W;         // exact product width
    localparam int SUM_W    = PROD_W - FRAC_W + 2; // three scaled products plus headroom
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_AX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CZ = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

    localparam logic signed [COORD_W-1:0] FIX_ONE  = COORD_W'(1) << FRAC_W;
    localparam logic signed [COORD_W-1:0] FIX_ZERO = '0;
    localparam logic signed [COORD_W-1:0] VMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] VMIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] value;
        logic                      flag;
    } t_sat;

    // results of the fractional to cartesian path, carried beside the solver
    typedef struct packed {
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] fz;
        logic                      fs;
    } t_fres;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        t_fres                     f;
    } t_side_z;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] oz;
        logic                      s;
        t_fres                     f;
    } t_side_y;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
        logic                      s;
        t_fres                     f;
    } t_side_x;

    // clamp a wide sum to the coordinate range
    function automatic t_sat sat_coord(input logic signed [SUM_W-1:0] v);
        t_sat r;
        logic fits;
        fits = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
        if (fits) begin
            r.value = v[COORD_W-1:0];
            r.flag  = 1'b0;
        end else begin
            r.value = v[SUM_W-1] ? VMIN : VMAX;
            r.flag  = 1'b1;
        end
        return r;
    endfunction

    // scaled product back to a sum-width value, arithmetic shift
    function automatic logic signed [SUM_W-1:0] scale(input logic signed [PROD_W-1:0] p);
        return SUM_W'(p >>> FRAC_W);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcc_div.sv =====
// pipelined signed fixed-point divider, one quotient bit per stage, saturating
`default_nettype none

module lcc_div #(
    parameter int NUM_W  = lcc_pkg::SUM_W,
    parameter int SIDE_W = 1
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  wire logic signed [NUM_W-1:0]         i_num,
    input  wire logic signed [lcc_pkg::COORD_W-1:0] i_den,
    input  wire logic [SIDE_W-1:0]               i_side,
    output logic                                 o_valid,
    output logic signed [lcc_pkg::COORD_W-1:0]   o_quo,
    output logic                                 o_sat,
    output logic [SIDE_W-1:0]                    o_side
);

    localparam int QW    = lcc_pkg::COORD_W;
    localparam int FW    = lcc_pkg::FRAC_W;
    localparam int HIW   = NUM_W - FW;
    localparam int CMP_W = HIW + QW;

    logic [NUM_W-1:0] n_num_mag;
    logic [QW-1:0]    n_den_mag;
    logic [HIW-1:0]   n_hi;
    logic             n_ovf;
    logic             n_neg;

    // divisor is static configuration, its magnitude is tracked every cycle
    logic [QW-1:0] r_dmag;

    logic              r_vld  [0:QW];
    logic [QW-1:0]     r_rem  [0:QW];
    logic [QW-1:0]     r_low  [0:QW];
    logic [QW-1:0]     r_q    [0:QW];
    logic              r_neg  [0:QW];
    logic              r_ovf  [0:QW];
    logic [SIDE_W-1:0] r_side [0:QW];

    always_comb begin
        n_num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_den_mag = i_den[QW-1] ? QW'(-i_den) : QW'(i_den);
        n_hi      = n_num_mag[NUM_W-1:FW];
        n_ovf     = CMP_W'(n_hi) >= CMP_W'(n_den_mag);
        n_neg     = i_num[NUM_W-1] ^ i_den[QW-1];
    end

    always_ff @(posedge i_clk) begin
        r_dmag <= n_den_mag;
    end

    // prep stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_hi[QW-1:0];
            r_low[0]  <= {n_num_mag[FW-1:0], {(QW-FW){1'b0}}};
            r_q[0]    <= '0;
            r_neg[0]  <= n_neg;
            r_ovf[0]  <= n_ovf;
            r_side[0] <= i_side;
        end
    end

    // restoring steps
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [QW:0] w_t;
        logic        w_ge;

        always_comb begin
            w_t  = {r_rem[k], r_low[k][QW-1]};
            w_ge = w_t >= {1'b0, r_dmag};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? QW'(w_t - {1'b0, r_dmag}) : w_t[QW-1:0];
                r_low[k+1]  <= {r_low[k][QW-2:0], 1'b0};
                r_q[k+1]    <= {r_q[k][QW-2:0], w_ge};
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // sign and clamp
    logic                 n_sat;
    logic signed [QW-1:0] n_quo;

    always_comb begin
        if (r_neg[QW]) begin
            n_sat = r_ovf[QW] || (r_q[QW][QW-1] && (|r_q[QW][QW-2:0]));
            n_quo = n_sat ? lcc_pkg::VMIN : QW'(-r_q[QW]);
        end else begin
            n_sat = r_ovf[QW] || r_q[QW][QW-1];
            n_quo = n_sat ? lcc_pkg::VMAX : r_q[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo  <= n_quo;
            o_sat  <= n_sat;
            o_side <= r_side[QW];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lattice_coordinate_conversion_unit.sv =====
// top level of the lattice coordinate conversion unit
`default_nettype none

// Converts one 3-D vector per item between fractional crystal coordinates and
// cartesian coordinates, all in signed q16.16. The lattice is a lower-triangular
// matrix (ax; bx by; cx cy cz) written through the cfg port; the user must
// write it only while no item is in flight, which the block does not enforce.
// tuser = 1 multiplies the fractional vector by the matrix; tuser = 0 solves the
// triangular system z, then y, then x with three pipelined 34-stage dividers in
// series, of one quotient bit per stage. The pipeline takes a new item every
// cycle while the output does not stall. The whole pipeline advances together
// whenever the output register is empty or taken; the input register still
// loads one item while a result waits. Output status is 0 ok, 1 zero diagonal
// entry on a solve (outputs are zero), 2 some component saturated.

module lattice_coordinate_conversion_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_data,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [95:0] s_axis_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
    input  wire  [0:0]  s_axis_tuser,   // command [0]
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);

    localparam int W  = lcc_pkg::COORD_W;
    localparam int PW = lcc_pkg::PROD_W;
    localparam int SW = lcc_pkg::SUM_W;

    // lattice registers
    logic signed [W-1:0] r_ax, r_bx, r_by, r_cx, r_cy, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= lcc_pkg::FIX_ONE;
            r_bx <= lcc_pkg::FIX_ZERO;
            r_by <= lcc_pkg::FIX_ONE;
            r_cx <= lcc_pkg::FIX_ZERO;
            r_cy <= lcc_pkg::FIX_ZERO;
            r_cz <= lcc_pkg::FIX_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lcc_pkg::REG_AX: r_ax <= i_cfg_data;
                lcc_pkg::REG_BX: r_bx <= i_cfg_data;
                lcc_pkg::REG_BY: r_by <= i_cfg_data;
                lcc_pkg::REG_CX: r_cx <= i_cfg_data;
                lcc_pkg::REG_CY: r_cy <= i_cfg_data;
                lcc_pkg::REG_CZ: r_cz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: input register
    logic                r_v0, r_cmd0;
    logic signed [W-1:0] r_x0, r_y0, r_z0;

    // global advance: output register free or being taken
    logic w_en;
    logic w_ld0;
    logic r_out_v;

    assign w_en          = !r_out_v || m_axis_tready;
    assign w_ld0         = w_en || !r_v0;
    assign s_axis_tready = w_ld0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_ld0) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld0) begin
            r_cmd0 <= s_axis_tuser[0];
            r_x0   <= s_axis_tdata[W-1:0];
            r_y0   <= s_axis_tdata[2*W-1:W];
            r_z0   <= s_axis_tdata[3*W-1:2*W];
        end
    end

    // stage 1: the six products of the forward transform
    logic                 r_v1, r_cmd1;
    logic signed [W-1:0]  r_x1, r_y1, r_z1;
    logic signed [PW-1:0] r_p_ax, r_p_bx, r_p_cx, r_p_by, r_p_cy, r_p_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd1 <= r_cmd0;
            r_x1   <= r_x0;
            r_y1   <= r_y0;
            r_z1   <= r_z0;
            r_p_ax <= r_x0 * r_ax;
            r_p_bx <= r_y0 * r_bx;
            r_p_cx <= r_z0 * r_cx;
            r_p_by <= r_y0 * r_by;
            r_p_cy <= r_z0 * r_cy;
            r_p_cz <= r_z0 * r_cz;
        end
    end

    // stage 2: sums and clamp of the forward transform
    logic                 r_v2;
    lcc_pkg::t_side_z     r_side2;
    logic signed [SW-1:0] n_sx, n_sy, n_sz;
    lcc_pkg::t_sat        n_tx, n_ty, n_tz;

    always_comb begin
        n_sx = lcc_pkg::scale(r_p_ax) + lcc_pkg::scale(r_p_bx) + lcc_pkg::scale(r_p_cx);
        n_sy = lcc_pkg::scale(r_p_by) + lcc_pkg::scale(r_p_cy);
        n_sz = lcc_pkg::scale(r_p_cz);
        n_tx = lcc_pkg::sat_coord(n_sx);
        n_ty = lcc_pkg::sat_coord(n_sy);
        n_tz = lcc_pkg::sat_coord(n_sz);
    end

    logic signed [W-1:0] r_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side2.cmd  <= r_cmd1;
            r_side2.x    <= r_x1;
            r_side2.y    <= r_y1;
            r_side2.f.fx <= n_tx.value;
            r_side2.f.fy <= n_ty.value;
            r_side2.f.fz <= n_tz.value;
            r_side2.f.fs <= n_tx.flag || n_ty.flag || n_tz.flag;
            r_z2         <= r_z1;
        end
    end

    // z = in_z / cz
    logic                 w_vz, w_satz;
    logic signed [W-1:0]  w_qz;
    lcc_pkg::t_side_z     w_side_z;

    lcc_div #(
        .NUM_W  (SW),
        .SIDE_W ($bits(lcc_pkg::t_side_z))
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_num   (SW'(r_z2)),
        .i_den   (r_cz),
        .i_side  (r_side2),
        .o_valid (w_vz),
        .o_quo   (w_qz),
        .o_sat   (w_satz),
        .o_side  (w_side_z)
    );

    // stage 3: z * cy
    logic                 r_v3, r_satz3;
    logic signed [W-1:0]  r_oz3;
    logic signed [PW-1:0] r_p_zcy;
    lcc_pkg::t_side_z     r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= w_vz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_satz3 <= w_satz;
            r_oz3   <= w_qz;
            r_p_zcy <= w_qz * r_cy;
            r_side3 <= w_side_z;
        end
    end

    // stage 4: numerator for y
    logic                 r_v4;
    logic signed [SW-1:0] r_ny;
    lcc_pkg::t_side_y     r_side4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ny        <= SW'(r_side3.y) - lcc_pkg::scale(r_p_zcy);
            r_side4.cmd <= r_side3.cmd;
            r_side4.x   <= r_side3.x;
            r_side4.oz  <= r_oz3;
            r_side4.s   <= r_satz3;
            r_side4.f   <= r_side3.f;
        end
    end

    // y = (in_y - z*cy) / by
    logic                 w_vy, w_saty;
    logic signed [W-1:0]  w_qy;
    lcc_pkg::t_side_y     w_side_y;

    lcc_div #(
        .NUM_W  (SW),
        .SIDE_W ($bits(lcc_pkg::t_side_y))
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (r_ny),
        .i_den   (r_by),
        .i_side  (r_side4),
        .o_valid (w_vy),
        .o_quo   (w_qy),
        .o_sat   (w_saty),
        .o_side  (w_side_y)
    );

    // stage 5: y * bx and z * cx
    logic                 r_v5;
    logic signed [W-1:0]  r_oy5;
    logic signed [PW-1:0] r_p_ybx, r_p_zcx;
    lcc_pkg::t_side_y     r_side5;
    logic                 r_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oy5   <= w_qy;
            r_p_ybx <= w_qy * r_bx;
            r_p_zcx <= w_side_y.oz * r_cx;
            r_side5 <= w_side_y;
            r_s5    <= w_side_y.s || w_saty;
        end
    end

    // stage 6: numerator for x
    logic                 r_v6;
    logic signed [SW-1:0] r_nx;
    lcc_pkg::t_side_x     r_side6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx <= SW'(r_side5.x) - lcc_pkg::scale(r_p_ybx) - lcc_pkg::scale(r_p_zcx);
            r_side6.cmd <= r_side5.cmd;
            r_side6.oy  <= r_oy5;
            r_side6.oz  <= r_side5.oz;
            r_side6.s   <= r_s5;
            r_side6.f   <= r_side5.f;
        end
    end

    // x = (in_x - y*bx - z*cx) / ax
    logic                 w_vx, w_satx;
    logic signed [W-1:0]  w_qx;
    lcc_pkg::t_side_x     w_side_x;

    lcc_div #(
        .NUM_W  (SW),
        .SIDE_W ($bits(lcc_pkg::t_side_x))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_num   (r_nx),
        .i_den   (r_ax),
        .i_side  (r_side6),
        .o_valid (w_vx),
        .o_quo   (w_qx),
        .o_sat   (w_satx),
        .o_side  (w_side_x)
    );

    // output register: pick forward result, zero-diagonal code or solver result
    logic                      w_zero_diag;
    logic signed [W-1:0]       n_ox, n_oy, n_oz;
    logic [lcc_pkg::STATUS_W-1:0] n_st;
    logic signed [W-1:0]       r_ox, r_oy, r_oz;
    logic [lcc_pkg::STATUS_W-1:0] r_st;

    assign w_zero_diag = (r_ax == lcc_pkg::FIX_ZERO) || (r_by == lcc_pkg::FIX_ZERO)
                      || (r_cz == lcc_pkg::FIX_ZERO);

    always_comb begin
        if (w_side_x.cmd) begin
            n_ox = w_side_x.f.fx;
            n_oy = w_side_x.f.fy;
            n_oz = w_side_x.f.fz;
            n_st = w_side_x.f.fs ? lcc_pkg::ST_SAT : lcc_pkg::ST_OK;
        end else if (w_zero_diag) begin
            n_ox = lcc_pkg::FIX_ZERO;
            n_oy = lcc_pkg::FIX_ZERO;
            n_oz = lcc_pkg::FIX_ZERO;
            n_st = lcc_pkg::ST_ZERO_DIV;
        end else begin
            n_ox = w_qx;
            n_oy = w_side_x.oy;
            n_oz = w_side_x.oz;
            n_st = (w_side_x.s || w_satx) ? lcc_pkg::ST_SAT : lcc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_vx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox <= n_ox;
            r_oy <= n_oy;
            r_oz <= n_oz;
            r_st <= n_st;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_oz, r_oy, r_ox};
    assign m_axis_tuser  = r_st;

    // input is only refused while a result waits at the output
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without an output stall");

    // zero-diagonal results carry zero vectors
    a_zero_div_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == lcc_pkg::ST_ZERO_DIV)) |-> (m_axis_tdata == '0))
        else $error("zero-diagonal item with nonzero data");

    // zero-diagonal code only when a diagonal entry really is zero
    a_zero_div_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == lcc_pkg::ST_ZERO_DIV)) |-> w_zero_diag)
        else $error("zero-diagonal code with nonzero diagonal");

endmodule

`default_nettype wire
